// ===== hw/rtl/mip_pkg.sv =====
// ----------------------------------------------------------------------------
// mip_pkg
// Shared types and constants of the minimum-insertion palindrome block.
// ----------------------------------------------------------------------------
package mip_pkg;
  localparam int MaxLen  = 32;
  localparam int IdxW    = $clog2(MaxLen);
  localparam int LenW    = $clog2(MaxLen + 1);
  localparam int AddrW   = 2 * IdxW;
  localparam int OutLenW = $clog2(2 * MaxLen);

  typedef logic [1:0] choice_t;
  localparam choice_t ChMatch = 2'd1;
  localparam choice_t ChLeft  = 2'd2;
  localparam choice_t ChRight = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [4:0] insert_count;
    logic       out_last;
  } out_item_t;
endpackage

// ===== hw/rtl/mip_dp_ram.sv =====
// ----------------------------------------------------------------------------
// mip_dp_ram
// Cost and choice table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mip_dp_ram
  import mip_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [6:0]       wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [6:0]       rdata
);
  logic [6:0] mem [2**AddrW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/min_insertion_palindrome.sv =====
// ----------------------------------------------------------------------------
// min_insertion_palindrome: builds the shortest palindrome of a byte string.
// After the last byte the table fills entry by entry, each entry passing through
// S_FA, S_FB and S_FC as the single table read port serves two reads each; the
// walk then builds the result, and results leave one at a time under out_ready.
// Non-final bytes are taken one per cycle. Synchronous reset clears length and
// control state; tables are not cleared as every entry read is written first.
// ----------------------------------------------------------------------------
module min_insertion_palindrome
  import mip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001, S_FA = 8'b00000010, S_FB = 8'b00000100,
    S_FC = 8'b00001000, S_WA = 8'b00010000, S_WB = 8'b00100000,
    S_TAIL = 8'b01000000, S_EMIT = 8'b10000000
  } state_t;

  state_t st_r;
  logic [7:0] chars [MaxLen];
  logic [7:0] rbuf [2*MaxLen];
  logic [LenW-1:0] n_r, len_r;
  logic [IdxW-1:0] i_r, j_r;
  logic [4:0] c1_r, cost_r;
  logic [OutLenW-1:0] lo_r, hi_r, k_r, tot_r;
  logic [7:0] rd_c;

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [6:0] wdata, rdata;

  mip_dp_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  logic [7:0] ci, cj;
  logic [IdxW-1:0] i1, jm;
  assign ci = chars[i_r];
  assign cj = chars[j_r];
  assign i1 = i_r + 1'b1;
  assign jm = j_r - 1'b1;
  logic inner_ok, l_ok, r_ok;
  assign inner_ok = (i1 < jm);
  assign l_ok = (i1 < j_r);
  assign r_ok = (i_r < jm);
  logic [4:0] c2;
  assign c2 = r_ok ? rdata[6:2] : 5'd0;

  always_comb begin
    raddr = {i1, j_r};
    unique case (st_r)
      S_FA:    raddr = (ci == cj) ? {i1, jm} : {i1, j_r};
      S_FB:    raddr = {i_r, jm};
      default: raddr = {i_r, j_r};
    endcase
  end

  assign we = (st_r == S_FC);
  assign waddr = {i_r, j_r};
  always_comb begin
    if (ci == cj) wdata = {c1_r, ChMatch};
    else if (c1_r < c2) wdata = {c1_r + 5'd1, ChLeft};
    else wdata = {c2 + 5'd1, ChRight};
  end

  assign in_ready  = (st_r == S_LOAD);
  assign out_valid = (st_r == S_EMIT);
  assign out_data  = '{out_char: rd_c, insert_count: cost_r,
                       out_last: (k_r + 1'b1 == tot_r)};

  logic [LenW-1:0] top;
  assign top = LenW'(i_r) + len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      n_r  <= '0;
    end else begin
      unique case (st_r)
        S_LOAD: if (in_valid) begin
          if (n_r < LenW'(MaxLen)) begin
            chars[n_r[IdxW-1:0]] <= in_data.in_char;
          end
          if (in_data.in_last) begin
            logic [LenW-1:0] nn;
            nn = (n_r < LenW'(MaxLen)) ? n_r + 1'b1 : n_r;
            n_r <= nn;
            if (nn != 0) begin
              len_r <= LenW'(2);
              i_r   <= '0;
              j_r   <= IdxW'(1);
              st_r  <= (nn == 1) ? S_WA : S_FA;
            end
          end else if (n_r < LenW'(MaxLen)) n_r <= n_r + 1'b1;
        end
        S_FA: st_r <= S_FB;
        S_FB: begin
          c1_r <= ((ci == cj) ? inner_ok : l_ok) ? rdata[6:2] : 5'd0;
          st_r <= S_FC;
        end
        S_FC: begin
          if (top < n_r) begin
            i_r <= i1; j_r <= j_r + 1'b1; st_r <= S_FA;
          end else if (len_r < n_r) begin
            len_r <= len_r + 1'b1; i_r <= '0;
            j_r <= IdxW'(len_r); st_r <= S_FA;
          end else begin
            st_r <= S_WA;
          end
        end
        S_WA: begin
          i_r <= '0; j_r <= IdxW'(n_r - 1'b1);
          lo_r <= '0; k_r <= '0;
          st_r <= S_WB;
          len_r <= '0;
        end
        S_WB: begin
          if (len_r == '0) begin
            cost_r <= (n_r > 1) ? rdata[6:2] : 5'd0;
            tot_r  <= OutLenW'(n_r) + ((n_r > 1) ? OutLenW'(rdata[6:2]) : '0);
            hi_r   <= OutLenW'(n_r) + ((n_r > 1) ? OutLenW'(rdata[6:2]) : '0);
            len_r  <= LenW'(1);
          end else if (i_r < j_r) begin
            logic [OutLenW-1:0] h;
            h = hi_r - 1'b1;
            unique case (rdata[1:0])
              ChMatch: begin
                rbuf[lo_r] <= ci; rbuf[h] <= cj; i_r <= i1; j_r <= jm;
              end
              ChLeft: begin
                rbuf[lo_r] <= ci; rbuf[h] <= ci; i_r <= i1;
              end
              default: begin
                rbuf[lo_r] <= cj; rbuf[h] <= cj; j_r <= jm;
              end
            endcase
            lo_r <= lo_r + 1'b1; hi_r <= h;
            st_r <= S_TAIL;
          end else begin
            if (i_r == j_r) rbuf[lo_r] <= ci;
            st_r <= S_TAIL; len_r <= LenW'(2);
          end
        end
        S_TAIL: begin
          if (len_r == LenW'(2)) begin
            rd_c <= rbuf[k_r]; st_r <= S_EMIT;
          end else st_r <= S_WB;
        end
        S_EMIT: if (out_ready) begin
          if (k_r + 1'b1 == tot_r) begin
            st_r <= S_LOAD; n_r <= '0;
          end else begin
            k_r <= k_r + 1'b1; st_r <= S_TAIL;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== hw/rtl/mip_checker.sv =====
// ----------------------------------------------------------------------------
// mip_checker
// Port-level checks of the palindrome block.
// ----------------------------------------------------------------------------
module mip_checker
  import mip_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready during output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.out_last |=> ##1
    $stable(out_data.insert_count)) else $error("count changed in string");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.out_last |=> in_ready)
    else $error("not ready after last item");
endmodule

bind min_insertion_palindrome mip_checker u_chk (.clk, .rst_n,
  .in_ready, .out_valid, .out_ready, .out_data);
